// ----- rtl/sps_pkg.sv -----
// Shared types, codes and constants for the subnet peer sweep block.
package sps_pkg;

  // Default interface table depth
  localparam int IFACE_MAX_DEF = 4;

  // Most results one tick may produce
  localparam int MAX_OUT = 64;

  // Input function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_LIMITED = 2'd0;
  localparam logic [1:0] KIND_SUBNET  = 2'd1;
  localparam logic [1:0] KIND_UNICAST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_UCAST_QUOTA     = 2'd0;
  localparam logic [1:0] REG_HOST_LIMIT      = 2'd1;
  localparam logic [1:0] REG_INTERFACE_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  UCAST_QUOTA_RST     = 6'd16;
  localparam logic [23:0] HOST_LIMIT_RST      = 24'd1022;
  localparam logic [2:0]  INTERFACE_COUNT_RST = 3'd0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // write a table entry from the input transaction
    logic restart;     // clear cursor, offset and laps
    logic tick_start;  // set up per-tick counters and budget
    logic push_lim;    // queue the limited broadcast
    logic push_sub;    // queue the directed broadcast of the walked entry
    logic eval;        // latch host range of the cursor entry
    logic step;        // move to the next host offset
    logic emit;        // queue the current unicast host
    logic advance;     // move cursor to the next interface
    logic flush;       // hand the held result out marked last
  } sps_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic used_zero;   // no interfaces in use
    logic sub_last;    // walking the final directed broadcast
    logic uni_done;    // unicast sweep exhausted for this tick
    logic budget_hit;  // unicast budget spent
    logic pass;        // cursor entry gives no (more) hosts
    logic host_self;   // current host is the interface's own address
    logic host_last;   // current host is the final one of the subnet
    logic can_push;    // a new result can be queued this cycle
    logic out_free;    // the output register can take a result
    logic pend_valid;  // a result is held back awaiting its last flag
  } sps_sts_t;

endpackage

// ----- rtl/sps_if.sv -----
// Channel interfaces: input items, result items and configuration writes.
interface sps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  entry_index;
  logic [31:0] iface_address;
  logic [31:0] iface_netmask;

  modport source (output valid, func, entry_index, iface_address, iface_netmask,
                  input ready);
  modport sink (input valid, func, entry_index, iface_address, iface_netmask,
                output ready);
endinterface

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_address;
  logic [1:0]  target_kind;
  logic        last;
  logic [15:0] lap_count;

  modport source (output valid, target_address, target_kind, last, lap_count,
                  input ready);
  modport sink (input valid, target_address, target_kind, last, lap_count,
                output ready);
endinterface

interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sps_datapath.sv -----
// Datapath: interface table, config registers, sweep counters and output stage.
module sps_datapath #(
  parameter int IFACE_MAX = sps_pkg::IFACE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sps_pkg::sps_cmd_t cmd,
  output sps_pkg::sps_sts_t sts,
  input  logic [1:0]       in_entry_index,
  input  logic [31:0]      in_iface_address,
  input  logic [31:0]      in_iface_netmask,
  input  logic             cfg_wr,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [31:0]      out_target_address,
  output logic [1:0]       out_target_kind,
  output logic             out_last,
  output logic [15:0]      out_lap_count
);

  localparam int CW = (IFACE_MAX > 1) ? $clog2(IFACE_MAX) : 1;
  localparam int UW = $clog2(IFACE_MAX + 1);
  localparam int EW = $clog2(IFACE_MAX + 2);

  // Interface table
  logic [31:0] tab_addr_r [IFACE_MAX];
  logic [31:0] tab_mask_r [IFACE_MAX];

  // Configuration
  logic [5:0]  budget_cfg_r;
  logic [23:0] host_limit_r;
  logic [2:0]  iface_count_r;

  // Sweep state
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [23:0]   offset_r, offset_nxt;
  logic [15:0]   laps_r, laps_nxt;
  logic [CW-1:0] sub_idx_r;
  logic [5:0]    sent_r;
  logic [5:0]    budget_r;
  logic [EW-1:0] examined_r;

  // Latched view of the cursor entry
  logic        skip_r;
  logic [23:0] hosts_r;
  logic [31:0] host_r;
  logic [31:0] self_r;

  // Held-back result and output register
  logic        pend_valid_r;
  logic [31:0] pend_addr_r;
  logic [1:0]  pend_kind_r;
  logic [15:0] pend_laps_r;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0]  out_kind_r;
  logic        out_last_r;
  logic [15:0] out_laps_r;

  logic [UW-1:0] used;
  logic [CW-1:0] rd_idx;
  logic [31:0]   rd_addr, rd_mask, span, hosts_full, subnet_bcast;
  logic          eval_skip, cursor_wrap, stale, push, out_free, can_push;
  logic [5:0]    budget_cap;
  logic [31:0]   new_addr;
  logic [1:0]    new_kind;

  // Interfaces in use, capped at the table depth
  assign used = (int'(iface_count_r) > IFACE_MAX) ? UW'(IFACE_MAX) : UW'(iface_count_r);

  // Single table read port: walk index during directed broadcasts, else cursor
  assign rd_idx  = cmd.push_sub ? sub_idx_r : cursor_r;
  assign rd_addr = tab_addr_r[rd_idx];
  assign rd_mask = tab_mask_r[rd_idx];

  // Host range of the selected entry
  assign span         = ~rd_mask;
  assign hosts_full   = (span < 32'd2) ? 32'd0 : span - 32'd1;
  assign eval_skip    = (hosts_full == 32'd0) || (hosts_full > {8'd0, host_limit_r});
  assign subnet_bcast = (rd_addr & rd_mask) | span;

  // Cursor movement
  assign cursor_wrap = (int'(cursor_r) + 1) == int'(used);
  assign stale       = (used != '0) && (int'(cursor_r) >= int'(used));

  // Unicast budget clipped so a tick stays within the result limit
  assign budget_cap = 6'(sps_pkg::MAX_OUT - 1) - 6'(used);

  // Output handshake bookkeeping
  assign out_free = !out_valid_r || out_ready;
  assign can_push = !pend_valid_r || out_free;
  assign push     = cmd.push_lim || cmd.push_sub || cmd.emit;

  // Select the result being queued
  always_comb begin
    new_addr = host_r;
    new_kind = sps_pkg::KIND_UNICAST;
    if (cmd.push_lim) begin
      new_addr = '1;
      new_kind = sps_pkg::KIND_LIMITED;
    end else if (cmd.push_sub) begin
      new_addr = subnet_bcast;
      new_kind = sps_pkg::KIND_SUBNET;
    end
  end

  // Next cursor, offset and laps
  always_comb begin
    cursor_nxt = cursor_r;
    offset_nxt = offset_r;
    laps_nxt   = laps_r;
    if (cmd.restart) begin
      cursor_nxt = '0;
      offset_nxt = '0;
      laps_nxt   = '0;
    end else if (cmd.tick_start) begin
      if (stale) begin
        cursor_nxt = '0;
        offset_nxt = '0;
      end
    end else if (cmd.advance) begin
      offset_nxt = '0;
      if (cursor_wrap) begin
        cursor_nxt = '0;
        laps_nxt   = laps_r + 16'd1;
      end else begin
        cursor_nxt = cursor_r + CW'(1);
      end
    end else if (cmd.step) begin
      offset_nxt = offset_r + 24'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_cfg_r  <= sps_pkg::UCAST_QUOTA_RST;
      host_limit_r  <= sps_pkg::HOST_LIMIT_RST;
      iface_count_r <= sps_pkg::INTERFACE_COUNT_RST;
      cursor_r      <= '0;
      offset_r      <= '0;
      laps_r        <= '0;
      sub_idx_r     <= '0;
      sent_r        <= '0;
      budget_r      <= '0;
      examined_r    <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          sps_pkg::REG_UCAST_QUOTA:     budget_cfg_r  <= cfg_data[5:0];
          sps_pkg::REG_HOST_LIMIT:      host_limit_r  <= cfg_data[23:0];
          sps_pkg::REG_INTERFACE_COUNT: iface_count_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      cursor_r <= cursor_nxt;
      offset_r <= offset_nxt;
      laps_r   <= laps_nxt;
      if (cmd.tick_start) begin
        sub_idx_r  <= '0;
        sent_r     <= '0;
        examined_r <= '0;
        budget_r   <= (budget_cfg_r < budget_cap) ? budget_cfg_r : budget_cap;
      end else begin
        if (cmd.push_sub) sub_idx_r <= sub_idx_r + CW'(1);
        if (cmd.emit)     sent_r <= sent_r + 6'd1;
        if (cmd.advance)  examined_r <= examined_r + EW'(1);
      end
      // Output stage: held result moves out when a newer one arrives or at flush
      if (cmd.flush || (push && pend_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Table writes, entry latches and result payloads
  always_ff @(posedge clk) begin
    for (int e = 0; e < IFACE_MAX; e++) begin
      if (cmd.load && (int'(in_entry_index) == e)) begin
        tab_addr_r[e] <= in_iface_address;
        tab_mask_r[e] <= in_iface_netmask;
      end
    end
    if (cmd.eval) begin
      skip_r  <= eval_skip;
      hosts_r <= hosts_full[23:0];
      host_r  <= (rd_addr & rd_mask) + 32'd1 + {8'd0, offset_r};
      self_r  <= rd_addr;
    end else if (cmd.step) begin
      host_r <= host_r + 32'd1;
    end
    if (push) begin
      pend_addr_r <= new_addr;
      pend_kind_r <= new_kind;
      pend_laps_r <= laps_r;
    end
    if (cmd.flush || (push && pend_valid_r)) begin
      out_addr_r <= pend_addr_r;
      out_kind_r <= pend_kind_r;
      out_laps_r <= pend_laps_r;
      out_last_r <= cmd.flush;
    end
  end

  // Status to the controller
  always_comb begin
    sts.used_zero  = (used == '0);
    sts.sub_last   = (int'(sub_idx_r) + 1) >= int'(used);
    sts.uni_done   = (sent_r >= budget_r) || (int'(examined_r) > int'(used));
    sts.budget_hit = (sent_r >= budget_r);
    sts.pass       = skip_r || (offset_r >= hosts_r);
    sts.host_self  = (host_r == self_r);
    sts.host_last  = ({1'b0, offset_r} + 25'd1) >= {1'b0, hosts_r};
    sts.can_push   = can_push;
    sts.out_free   = out_free;
    sts.pend_valid = pend_valid_r;
  end

  assign out_valid          = out_valid_r;
  assign out_target_address = out_addr_r;
  assign out_target_kind    = out_kind_r;
  assign out_last           = out_last_r;
  assign out_lap_count      = out_laps_r;

endmodule

// ----- rtl/sps_ctrl.sv -----
// Controller: sequences loads, restarts and the per-tick sweep.
module sps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  sps_pkg::sps_sts_t sts,
  output sps_pkg::sps_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMITED,
    S_SUBNET,
    S_UEVAL,
    S_UHOST,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            sps_pkg::FUNC_LOAD:    cmd.load = 1'b1;
            sps_pkg::FUNC_RESTART: cmd.restart = 1'b1;
            sps_pkg::FUNC_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = S_LIMITED;
            end
            default: ;
          endcase
        end
      end
      S_LIMITED: begin
        if (sts.can_push) begin
          cmd.push_lim = 1'b1;
          state_nxt    = sts.used_zero ? S_FLUSH : S_SUBNET;
        end
      end
      S_SUBNET: begin
        if (sts.can_push) begin
          cmd.push_sub = 1'b1;
          if (sts.sub_last) state_nxt = S_UEVAL;
        end
      end
      S_UEVAL: begin
        if (sts.uni_done) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = S_UHOST;
        end
      end
      S_UHOST: begin
        if (sts.budget_hit) begin
          state_nxt = S_FLUSH;
        end else if (sts.pass) begin
          // skipped subnet or offset already past its range
          cmd.advance = 1'b1;
          state_nxt   = S_UEVAL;
        end else if (sts.host_self || sts.can_push) begin
          // own address is stepped over without a result
          cmd.step = 1'b1;
          cmd.emit = !sts.host_self;
          if (sts.host_last) begin
            cmd.advance = 1'b1;
            state_nxt   = S_UEVAL;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/subnet_peer_sweep_core.sv -----
// Top level of the subnet peer sweep target generator.
// Usage:
//   in_ch  carries one transaction per item: func selects a table load
//          (entry_index, iface_address, iface_netmask), a sweep restart or a
//          tick. Loads and restarts give no result.
//   out_ch carries the probe targets of a tick: the limited broadcast, one
//          directed broadcast per interface in use, then unicast hosts; last
//          marks the final transaction of the tick.
//   cfg_ch writes the unicast quota (0), host_limit (1), interface_count (2);
//          it is always ready and may only be used while the block is idle.
// Sequence: a tick starts the sweep from idle; results are queued in order,
//   with a stall whenever the staging register cannot pass one on, and the
//   unicast sweep evaluates each interface it visits before stepping through
//   its hosts, stepping over the own address without a result. in_ch.ready
//   stays low until the last result is in the output register: one item at a time.
// Each result waits in a staging register until the next one is queued or the
//   tick ends, so the last flag is known before it reaches the output register;
//   a stall on out_ch stalls the sweep without loss.
// Reset clears the configuration to its defaults, the cursor, host offset
//   and laps; table entries hold nothing until loaded.
module subnet_peer_sweep_core #(
  parameter int IFACE_MAX = sps_pkg::IFACE_MAX_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch,
  sps_cfg_if.sink   cfg_ch
);

  sps_pkg::sps_cmd_t cmd;
  sps_pkg::sps_sts_t sts;
  logic              cfg_wr;

  // Configuration port is always open
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sps_datapath #(
    .IFACE_MAX (IFACE_MAX)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_entry_index     (in_ch.entry_index),
    .in_iface_address   (in_ch.iface_address),
    .in_iface_netmask   (in_ch.iface_netmask),
    .cfg_wr             (cfg_wr),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_target_address (out_ch.target_address),
    .out_target_kind    (out_ch.target_kind),
    .out_last           (out_ch.last),
    .out_lap_count      (out_ch.lap_count)
  );

  // A tick keeps the input closed while it runs
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.func == sps_pkg::FUNC_TICK) |=> !in_ch.ready)
    else $error("input ready right after a tick transaction");

  // Nothing is left staged once the block is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.pend_valid)
    else $error("staged result left behind at idle");

  // Limited broadcast always carries the all-ones address
  a_limited_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.target_kind == sps_pkg::KIND_LIMITED)
      |-> (out_ch.target_address == 32'hFFFF_FFFF))
    else $error("limited broadcast with wrong address");

endmodule
